>>> rtl/core/i2cm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// i2cm_pkg
// Shared types and codes of the bit-level i2c master sequencer.
// ----------------------------------------------------------------------------
package i2cm_pkg;

    localparam int BYTE_BITS     = 8;
    localparam int CFG_DATA_BITS = 16;

    // request codes
    localparam logic [2:0] REQ_NONE    = 3'd0;
    localparam logic [2:0] REQ_START   = 3'd1;
    localparam logic [2:0] REQ_RESTART = 3'd2;
    localparam logic [2:0] REQ_WRITE   = 3'd3;
    localparam logic [2:0] REQ_READ    = 3'd4;
    localparam logic [2:0] REQ_STOP    = 3'd5;

    // error codes
    localparam logic [1:0] ERR_NONE     = 2'd0;
    localparam logic [1:0] ERR_START    = 2'd1;
    localparam logic [1:0] ERR_NO_ACK   = 2'd2;

    // configuration register indexes
    localparam logic CFG_LINE_DELAY      = 1'b0;
    localparam logic CFG_STRETCH_TIMEOUT = 1'b1;

    localparam logic [3:0] BITS_PER_BYTE = 4'd8;
    localparam logic [15:0] LINE_DELAY_RST      = 16'd10;
    localparam logic [15:0] STRETCH_TIMEOUT_RST = 16'd100;

    typedef enum logic [4:0] {
        PH_IDLE = 5'd0,
        PH_S0   = 5'd1,
        PH_S1   = 5'd2,
        PH_S2   = 5'd3,
        PH_S3   = 5'd4,
        PH_FIN  = 5'd5,
        PH_P0   = 5'd6,
        PH_P1   = 5'd7,
        PH_P2   = 5'd8,
        PH_P3   = 5'd9,
        PH_P4   = 5'd10,
        PH_W0   = 5'd11,
        PH_W1   = 5'd12,
        PH_W2   = 5'd13,
        PH_W3   = 5'd14,
        PH_W4   = 5'd15,
        PH_W5   = 5'd16,
        PH_W6   = 5'd17,
        PH_W7   = 5'd18,
        PH_W8   = 5'd19,
        PH_W9   = 5'd20,
        PH_R0   = 5'd21,
        PH_R1   = 5'd22,
        PH_R2   = 5'd23,
        PH_R3   = 5'd24,
        PH_R4   = 5'd25,
        PH_R5   = 5'd26,
        PH_R6   = 5'd27,
        PH_R7   = 5'd28
    } phase_t;

    typedef struct packed {
        phase_t                phase;
        logic [3:0]            bit_index;
        logic [BYTE_BITS-1:0]  shift_byte;
        logic                  scl_drive;
        logic                  sda_drive;
        logic                  nack_pending;
        logic [BYTE_BITS-1:0]  rx_hold;
        logic [1:0]            err_hold;
    } seq_state_t;

endpackage
`default_nettype wire

>>> rtl/core/i2cm_step.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// i2cm_step
// Next-state logic of the sequencer for one tick: hold countdown, command
// accept and one bus step.
// ----------------------------------------------------------------------------
module i2cm_step
    import i2cm_pkg::*;
#(
    parameter int COUNT_BITS = 16
) (
    input  seq_state_t             st_i,
    input  logic [COUNT_BITS-1:0]  delay_i,
    input  logic [COUNT_BITS-1:0]  stretch_i,
    input  logic [COUNT_BITS-1:0]  line_delay_i,
    input  logic [COUNT_BITS-1:0]  stretch_timeout_i,
    input  logic [2:0]             req_type_i,
    input  logic [BYTE_BITS-1:0]   tx_byte_i,
    input  logic                   send_nack_i,
    input  logic                   scl_i,
    input  logic                   sda_i,
    output seq_state_t             st_o,
    output logic [COUNT_BITS-1:0]  delay_o,
    output logic [COUNT_BITS-1:0]  stretch_o,
    output logic                   done_o
);

    always_comb begin
        seq_state_t            n;
        logic [COUNT_BITS-1:0] dn;
        logic [COUNT_BITS-1:0] sn;
        logic                  run;
        logic                  budget;

        n      = st_i;
        dn     = delay_i;
        sn     = stretch_i;
        done_o = 1'b0;
        run    = 1'b0;

        if (st_i.phase == PH_IDLE) begin
            dn = '0;
            if (req_type_i == REQ_START || req_type_i == REQ_RESTART ||
                req_type_i == REQ_WRITE || req_type_i == REQ_READ ||
                req_type_i == REQ_STOP) begin
                n.err_hold  = ERR_NONE;
                n.bit_index = '0;
                sn          = '0;
                run         = 1'b1;
                priority case (req_type_i)
                    REQ_WRITE: begin
                        n.shift_byte = tx_byte_i;
                        n.phase      = PH_W0;
                    end
                    REQ_READ: begin
                        n.shift_byte   = '0;
                        n.nack_pending = send_nack_i;
                        n.phase        = PH_R0;
                    end
                    REQ_STOP: n.phase = PH_P0;
                    default:  n.phase = PH_S0;
                endcase
            end
        end else if (delay_i != '0) begin
            dn = delay_i - 1'b1;
        end else begin
            run = 1'b1;
        end

        budget = (sn < stretch_timeout_i);

        if (run) begin
            unique case (n.phase)
                PH_S0: begin n.sda_drive = 1'b1; dn = line_delay_i; n.phase = PH_S1; end
                PH_S1: begin
                    n.scl_drive = 1'b1; dn = line_delay_i; sn = '0; n.phase = PH_S2;
                end
                PH_S2: begin
                    if (!scl_i && budget) begin
                        sn = sn + 1'b1; dn = line_delay_i;
                    end else if (!sda_i) begin
                        n.phase = PH_IDLE; dn = '0; done_o = 1'b1; n.err_hold = ERR_START;
                    end else begin
                        n.sda_drive = 1'b0; dn = line_delay_i; n.phase = PH_S3;
                    end
                end
                PH_S3: begin
                    if (sda_i) begin
                        n.phase = PH_IDLE; dn = '0; done_o = 1'b1; n.err_hold = ERR_START;
                    end else begin
                        n.scl_drive = 1'b0; dn = line_delay_i; n.phase = PH_FIN;
                    end
                end
                PH_FIN: begin
                    n.phase = PH_IDLE; dn = '0; done_o = 1'b1; n.err_hold = ERR_NONE;
                end

                PH_P0: begin n.scl_drive = 1'b0; dn = line_delay_i; n.phase = PH_P1; end
                PH_P1: begin n.sda_drive = 1'b0; dn = line_delay_i; n.phase = PH_P2; end
                PH_P2: begin n.scl_drive = 1'b1; sn = '0; n.phase = PH_P3; end
                PH_P3: begin
                    if (!scl_i && budget) begin
                        sn = sn + 1'b1; dn = line_delay_i;
                    end else begin
                        dn = line_delay_i; n.phase = PH_P4;
                    end
                end
                PH_P4: begin n.sda_drive = 1'b1; dn = line_delay_i; n.phase = PH_FIN; end

                PH_W0: begin n.scl_drive = 1'b0; dn = line_delay_i; n.phase = PH_W1; end
                PH_W1: begin
                    n.sda_drive = n.shift_byte[BYTE_BITS-1]; dn = line_delay_i;
                    n.phase = PH_W2;
                end
                PH_W2: begin n.scl_drive = 1'b1; dn = line_delay_i; n.phase = PH_W3; end
                PH_W3: begin
                    if (!scl_i && budget) begin
                        sn = sn + 1'b1; dn = line_delay_i;
                    end else begin
                        dn           = line_delay_i;
                        n.shift_byte = {n.shift_byte[BYTE_BITS-2:0], 1'b0};
                        n.bit_index  = n.bit_index + 1'b1;
                        n.phase      = (n.bit_index >= BITS_PER_BYTE) ? PH_W4 : PH_W0;
                    end
                end
                PH_W4: begin
                    n.scl_drive = 1'b0; sn = '0; dn = line_delay_i; n.phase = PH_W5;
                end
                PH_W5: begin n.scl_drive = 1'b0; dn = line_delay_i; n.phase = PH_W6; end
                PH_W6: begin n.sda_drive = 1'b1; dn = line_delay_i; n.phase = PH_W7; end
                PH_W7: begin
                    // wait for the slave to pull sda low
                    if (sda_i && budget) begin
                        sn = sn + 1'b1; dn = line_delay_i;
                    end else if (sda_i) begin
                        n.phase = PH_IDLE; dn = '0; done_o = 1'b1; n.err_hold = ERR_NO_ACK;
                    end else begin
                        n.scl_drive = 1'b1; n.phase = PH_W8;
                    end
                end
                PH_W8: begin
                    if (!scl_i && budget) begin
                        sn = sn + 1'b1; dn = line_delay_i;
                    end else begin
                        dn = line_delay_i; n.phase = PH_W9;
                    end
                end
                PH_W9: begin
                    n.scl_drive = 1'b0;
                    n.phase = PH_IDLE; dn = '0; done_o = 1'b1; n.err_hold = ERR_NONE;
                end

                PH_R0: begin
                    n.sda_drive = 1'b1; n.scl_drive = 1'b0; dn = line_delay_i;
                    n.phase = PH_R1;
                end
                PH_R1: begin n.scl_drive = 1'b1; n.phase = PH_R2; end
                PH_R2: begin
                    if (!scl_i && budget) begin
                        sn = sn + 1'b1; dn = line_delay_i;
                    end else begin
                        dn = line_delay_i; n.phase = PH_R3;
                    end
                end
                PH_R3: begin
                    n.shift_byte = {n.shift_byte[BYTE_BITS-2:0], sda_i};
                    n.bit_index  = n.bit_index + 1'b1;
                    n.scl_drive  = 1'b0;
                    dn           = line_delay_i;
                    if (n.bit_index >= BITS_PER_BYTE) begin
                        n.rx_hold = n.shift_byte;
                        sn        = '0;
                        n.phase   = PH_R4;
                    end else begin
                        n.phase = PH_R1;
                    end
                end
                PH_R4: begin
                    n.sda_drive = n.nack_pending; dn = line_delay_i; n.phase = PH_R5;
                end
                PH_R5: begin n.scl_drive = 1'b1; n.phase = PH_R6; end
                PH_R6: begin
                    if (!scl_i && budget) begin
                        sn = sn + 1'b1; dn = line_delay_i;
                    end else begin
                        dn = line_delay_i; n.phase = PH_R7;
                    end
                end
                PH_R7: begin n.scl_drive = 1'b0; dn = line_delay_i; n.phase = PH_FIN; end

                default: begin n.phase = PH_IDLE; dn = '0; end
            endcase
        end

        st_o      = n;
        delay_o   = dn;
        stretch_o = sn;
    end

endmodule
`default_nettype wire

>>> rtl/core/i2c_bit_level_master.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// i2c_bit_level_master
// Open-drain i2c master sequencer advanced by one tick word per cycle.
// ----------------------------------------------------------------------------
// Each input word is one bus tick: the sampled scl and sda levels plus a
// request (start, restart, write byte, read byte, stop) that is taken only
// while the sequencer is idle. Each accepted word yields exactly one result
// word with the line releases, busy, a one-tick done pulse, the last read
// byte and the error code of the last command.
// The result of a tick sits in the output register the cycle after the tick is
// accepted. Throughput is one tick per cycle while s_ready is high; the step
// logic plus the sequencer registers close the loop with no extra register.
// s_ready stays high while the output register is empty or being drained,
// so a stall on m_ready holds one result and then stops the input side.
// Reset leaves the sequencer idle with both lines released, rx byte and
// error code zero, line_delay 10 and stretch_timeout 100. Configuration is
// written through cfg_we/cfg_index/cfg_wdata while no tick is in flight.
// ----------------------------------------------------------------------------
module i2c_bit_level_master
    import i2cm_pkg::*;
#(
    parameter int COUNT_BITS = 16
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,

    input  wire logic                      cfg_we,
    input  wire logic                      cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0]  cfg_wdata,

    input  wire logic                      s_valid,
    output      logic                      s_ready,
    input  wire logic [2:0]                s_req_type,
    input  wire logic [BYTE_BITS-1:0]      s_tx_byte,
    input  wire logic                      s_send_nack,
    input  wire logic                      s_scl_level,
    input  wire logic                      s_sda_level,

    output      logic                      m_valid,
    input  wire logic                      m_ready,
    output      logic                      m_scl_release,
    output      logic                      m_sda_release,
    output      logic                      m_busy_res,
    output      logic                      m_done_res,
    output      logic [BYTE_BITS-1:0]      m_rx_byte,
    output      logic [1:0]                m_error_code
);

    logic [CFG_DATA_BITS-1:0] line_delay_reg;
    logic [CFG_DATA_BITS-1:0] stretch_timeout_reg;

    seq_state_t               st_reg, st_next;
    logic [COUNT_BITS-1:0]    delay_reg, delay_next;
    logic [COUNT_BITS-1:0]    stretch_reg, stretch_next;
    logic                     done_next;

    logic                     m_valid_reg;
    logic                     scl_rel_reg, sda_rel_reg, busy_reg, done_reg;
    logic [BYTE_BITS-1:0]     rx_byte_reg;
    logic [1:0]               err_reg;

    logic                     accept;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    i2cm_step #(
        .COUNT_BITS(COUNT_BITS)
    ) u_step (
        .st_i              (st_reg),
        .delay_i           (delay_reg),
        .stretch_i         (stretch_reg),
        .line_delay_i      (COUNT_BITS'(line_delay_reg)),
        .stretch_timeout_i (COUNT_BITS'(stretch_timeout_reg)),
        .req_type_i        (s_req_type),
        .tx_byte_i         (s_tx_byte),
        .send_nack_i       (s_send_nack),
        .scl_i             (s_scl_level),
        .sda_i             (s_sda_level),
        .st_o              (st_next),
        .delay_o           (delay_next),
        .stretch_o         (stretch_next),
        .done_o            (done_next)
    );

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            line_delay_reg      <= LINE_DELAY_RST;
            stretch_timeout_reg <= STRETCH_TIMEOUT_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_LINE_DELAY:      line_delay_reg      <= cfg_wdata;
                CFG_STRETCH_TIMEOUT: stretch_timeout_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // sequencer state advances once per accepted word
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg.phase        <= PH_IDLE;
            st_reg.bit_index    <= '0;
            st_reg.shift_byte   <= '0;
            st_reg.scl_drive    <= 1'b1;
            st_reg.sda_drive    <= 1'b1;
            st_reg.nack_pending <= 1'b0;
            st_reg.rx_hold      <= '0;
            st_reg.err_hold     <= ERR_NONE;
            delay_reg           <= '0;
            stretch_reg         <= '0;
        end else if (accept) begin
            st_reg      <= st_next;
            delay_reg   <= delay_next;
            stretch_reg <= stretch_next;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            scl_rel_reg <= st_next.scl_drive;
            sda_rel_reg <= st_next.sda_drive;
            busy_reg    <= (st_next.phase != PH_IDLE);
            done_reg    <= done_next;
            rx_byte_reg <= st_next.rx_hold;
            err_reg     <= st_next.err_hold;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_scl_release = scl_rel_reg;
    assign m_sda_release = sda_rel_reg;
    assign m_busy_res    = busy_reg;
    assign m_done_res    = done_reg;
    assign m_rx_byte     = rx_byte_reg;
    assign m_error_code  = err_reg;

endmodule
`default_nettype wire

>>> tb/i2c_bit_level_master_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_bit_level_master_tb
// Self-checking bench for the bit-level i2c master sequencer.
// ----------------------------------------------------------------------------
// Every tick word sent to the block also runs through a cycle-exact predictor
// of the sequencer, and the predicted result word is queued. A checker pops
// the queue on each accepted result word and compares every field. Bus levels
// come from a small slave model fed by the predicted line drives: clock
// stretching, acknowledge, nack, late ack, read data, stuck sda and noise.
// Directed tests cover reset defaults, every command, spare request codes,
// commands while busy, start failures, missing ack, stretch budgets and the
// delay extremes, followed by random transactions over several settings.
// ----------------------------------------------------------------------------
module i2c_bit_level_master_tb;
    import i2cm_pkg::*;

    localparam logic [2:0] REQ_SPARE6    = 3'd6;
    localparam logic [2:0] REQ_SPARE7    = 3'd7;
    localparam int         IDLE_WAIT_MAX = 100000;
    localparam int         MAX_REPORTS   = 200;

    typedef struct packed {
        logic       scl;
        logic       sda;
        logic       busy;
        logic       done;
        logic [7:0] rx;
        logic [1:0] err;
    } tick_res_t;

    logic                     aclk;
    logic                     aresetn;
    logic                     cfg_we;
    logic                     cfg_index;
    logic [CFG_DATA_BITS-1:0] cfg_wdata;
    logic                     s_valid;
    logic                     s_ready;
    logic [2:0]               s_req_type;
    logic [BYTE_BITS-1:0]     s_tx_byte;
    logic                     s_send_nack;
    logic                     s_scl_level;
    logic                     s_sda_level;
    logic                     m_valid;
    logic                     m_ready;
    logic                     m_scl_release;
    logic                     m_sda_release;
    logic                     m_busy_res;
    logic                     m_done_res;
    logic [BYTE_BITS-1:0]     m_rx_byte;
    logic [1:0]               m_error_code;

    i2c_bit_level_master u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_req_type    (s_req_type),
        .s_tx_byte     (s_tx_byte),
        .s_send_nack   (s_send_nack),
        .s_scl_level   (s_scl_level),
        .s_sda_level   (s_sda_level),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_scl_release (m_scl_release),
        .m_sda_release (m_sda_release),
        .m_busy_res    (m_busy_res),
        .m_done_res    (m_done_res),
        .m_rx_byte     (m_rx_byte),
        .m_error_code  (m_error_code)
    );

    // sequencer predictor state
    logic [15:0] line_delay_cfg    = LINE_DELAY_RST;
    logic [15:0] stretch_limit_cfg = STRETCH_TIMEOUT_RST;
    phase_t      seq_phase         = PH_IDLE;
    logic [3:0]  bit_cnt           = '0;
    logic [7:0]  shreg             = '0;
    logic [15:0] hold_cnt          = '0;
    logic [15:0] stretch_cnt       = '0;
    logic        scl_out           = 1'b1;
    logic        sda_out           = 1'b1;
    logic        nack_flag         = 1'b0;
    logic [7:0]  rx_last           = '0;
    logic [1:0]  err_last          = ERR_NONE;
    logic        done_flag         = 1'b0;

    tick_res_t   tick_res_q[$];
    tick_res_t   want;
    int          fail_cnt = 0;

    // slave and bus knobs
    logic        ack_refuse     = 1'b0;
    int          ack_late       = 0;
    logic [7:0]  slave_byte     = '0;
    bit          force_sda_low  = 0;
    bit          force_sda_high = 0;
    int          stretch_pct    = 0;
    int          stretch_max    = 1;
    int          stretch_left   = 0;
    int          noise_permil   = 0;
    int          stuck_permil   = 0;
    int          stuck_left     = 0;
    int          busy_cmd_pct   = 5;

    // traffic shaping
    bit          gaps_on     = 1;
    bit          rx_stall_on = 1;
    int          burst_left  = 0;
    int          hold_left   = 0;
    int          rx_tick     = 0;

    always #10 aclk = ~aclk;

    // ------------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------------
    function automatic void seq_hold();
        hold_cnt = line_delay_cfg;
    endfunction

    // one wait step while the line is low and budget remains
    function automatic bit seq_wait(input logic level_high);
        if (!level_high && stretch_cnt < stretch_limit_cfg) begin
            stretch_cnt = stretch_cnt + 16'd1;
            seq_hold();
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic void seq_finish(input logic [1:0] err);
        seq_phase = PH_IDLE;
        hold_cnt  = '0;
        done_flag = 1'b1;
        err_last  = err;
    endfunction

    function automatic void seq_step(input logic scl, input logic sda);
        case (seq_phase)
            PH_S0: begin
                sda_out = 1'b1; seq_hold(); seq_phase = PH_S1;
            end
            PH_S1: begin
                scl_out = 1'b1; seq_hold(); stretch_cnt = '0; seq_phase = PH_S2;
            end
            PH_S2: begin
                if (!seq_wait(scl)) begin
                    if (!sda) begin
                        seq_finish(ERR_START);
                    end else begin
                        sda_out = 1'b0; seq_hold(); seq_phase = PH_S3;
                    end
                end
            end
            PH_S3: begin
                if (sda) begin
                    seq_finish(ERR_START);
                end else begin
                    scl_out = 1'b0; seq_hold(); seq_phase = PH_FIN;
                end
            end
            PH_FIN: seq_finish(ERR_NONE);
            PH_P0: begin
                scl_out = 1'b0; seq_hold(); seq_phase = PH_P1;
            end
            PH_P1: begin
                sda_out = 1'b0; seq_hold(); seq_phase = PH_P2;
            end
            PH_P2: begin
                scl_out = 1'b1; stretch_cnt = '0; seq_phase = PH_P3;
            end
            PH_P3: begin
                if (!seq_wait(scl)) begin
                    seq_hold(); seq_phase = PH_P4;
                end
            end
            PH_P4: begin
                sda_out = 1'b1; seq_hold(); seq_phase = PH_FIN;
            end
            PH_W0: begin
                scl_out = 1'b0; seq_hold(); seq_phase = PH_W1;
            end
            PH_W1: begin
                sda_out = shreg[7]; seq_hold(); seq_phase = PH_W2;
            end
            PH_W2: begin
                scl_out = 1'b1; seq_hold(); seq_phase = PH_W3;
            end
            PH_W3: begin
                if (!seq_wait(scl)) begin
                    seq_hold();
                    shreg     = {shreg[6:0], 1'b0};
                    bit_cnt   = bit_cnt + 4'd1;
                    seq_phase = (bit_cnt >= BITS_PER_BYTE) ? PH_W4 : PH_W0;
                end
            end
            PH_W4: begin
                scl_out = 1'b0; stretch_cnt = '0; seq_hold(); seq_phase = PH_W5;
            end
            PH_W5: begin
                scl_out = 1'b0; seq_hold(); seq_phase = PH_W6;
            end
            PH_W6: begin
                sda_out = 1'b1; seq_hold(); seq_phase = PH_W7;
            end
            PH_W7: begin
                // wait while sda still reads high
                if (!seq_wait(!sda)) begin
                    if (sda) begin
                        seq_finish(ERR_NO_ACK);
                    end else begin
                        scl_out = 1'b1; seq_phase = PH_W8;
                    end
                end
            end
            PH_W8: begin
                if (!seq_wait(scl)) begin
                    seq_hold(); seq_phase = PH_W9;
                end
            end
            PH_W9: begin
                scl_out = 1'b0; seq_finish(ERR_NONE);
            end
            PH_R0: begin
                sda_out = 1'b1; scl_out = 1'b0; seq_hold(); seq_phase = PH_R1;
            end
            PH_R1: begin
                scl_out = 1'b1; seq_phase = PH_R2;
            end
            PH_R2: begin
                if (!seq_wait(scl)) begin
                    seq_hold(); seq_phase = PH_R3;
                end
            end
            PH_R3: begin
                shreg   = {shreg[6:0], sda};
                bit_cnt = bit_cnt + 4'd1;
                scl_out = 1'b0;
                seq_hold();
                if (bit_cnt >= BITS_PER_BYTE) begin
                    rx_last     = shreg;
                    stretch_cnt = '0;
                    seq_phase   = PH_R4;
                end else begin
                    seq_phase = PH_R1;
                end
            end
            PH_R4: begin
                sda_out = nack_flag; seq_hold(); seq_phase = PH_R5;
            end
            PH_R5: begin
                scl_out = 1'b1; seq_phase = PH_R6;
            end
            PH_R6: begin
                if (!seq_wait(scl)) begin
                    seq_hold(); seq_phase = PH_R7;
                end
            end
            PH_R7: begin
                scl_out = 1'b0; seq_hold(); seq_phase = PH_FIN;
            end
            default: begin
                seq_phase = PH_IDLE; hold_cnt = '0;
            end
        endcase
    endfunction

    function automatic tick_res_t predict_tick(input logic [2:0] req, input logic [7:0] tx,
                                               input logic nck, input logic scl,
                                               input logic sda);
        tick_res_t res;
        done_flag = 1'b0;
        if (seq_phase == PH_IDLE) begin
            hold_cnt = '0;
            if (req >= REQ_START && req <= REQ_STOP) begin
                err_last    = ERR_NONE;
                bit_cnt     = '0;
                stretch_cnt = '0;
                case (req)
                    REQ_START, REQ_RESTART: seq_phase = PH_S0;
                    REQ_WRITE: begin
                        shreg = tx; seq_phase = PH_W0;
                    end
                    REQ_READ: begin
                        shreg = '0; nack_flag = nck; seq_phase = PH_R0;
                    end
                    default: seq_phase = PH_P0;
                endcase
                seq_step(scl, sda);
            end
        end else if (hold_cnt != 0) begin
            hold_cnt = hold_cnt - 16'd1;
        end else begin
            seq_step(scl, sda);
        end
        res.scl  = scl_out;
        res.sda  = sda_out;
        res.busy = (seq_phase != PH_IDLE);
        res.done = done_flag;
        res.rx   = rx_last;
        res.err  = err_last;
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // bus model: levels seen on the next tick from the current drives
    // ------------------------------------------------------------------------
    function automatic void bus_levels(output logic scl, output logic sda);
        logic slave_sda;
        if (stretch_left != 0) begin
            stretch_left--;
        end else if (scl_out && stretch_pct != 0 && $urandom_range(0, 99) < stretch_pct) begin
            stretch_left = $urandom_range(1, stretch_max);
        end
        if (stuck_left != 0) begin
            stuck_left--;
        end else if (seq_phase == PH_IDLE && stuck_permil != 0 &&
                     $urandom_range(0, 999) < stuck_permil) begin
            stuck_left = $urandom_range(1, 8);
        end
        slave_sda = 1'b1;
        case (seq_phase)
            PH_W7: begin
                if (ack_late != 0) ack_late--;
                else slave_sda = ack_refuse;
            end
            PH_W8, PH_W9: slave_sda = ack_refuse;
            PH_R1, PH_R2, PH_R3: slave_sda = slave_byte[3'(4'd7 - bit_cnt)];
            default: ;
        endcase
        scl = scl_out && (stretch_left == 0);
        if (force_sda_low || stuck_left != 0) sda = 1'b0;
        else if (force_sda_high) sda = 1'b1;
        else sda = sda_out & slave_sda;
        if (noise_permil != 0 && $urandom_range(0, 999) < noise_permil) sda = ~sda;
        if (noise_permil != 0 && $urandom_range(0, 999) < noise_permil) scl = ~scl;
    endfunction

    function automatic logic [2:0] busy_req();
        if ($urandom_range(0, 99) < busy_cmd_pct) return 3'($urandom_range(REQ_NONE, REQ_SPARE7));
        return REQ_NONE;
    endfunction

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------
    task automatic send_tick(input logic [2:0] req, input logic [7:0] tx, input logic nck);
        logic scl_l;
        logic sda_l;
        if (burst_left == 0) begin
            if (gaps_on) begin
                repeat ($urandom_range(1, 6)) begin
                    @(negedge aclk);
                    s_valid = 1'b0;
                end
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        bus_levels(scl_l, sda_l);
        @(negedge aclk);
        s_valid     = 1'b1;
        s_req_type  = req;
        s_tx_byte   = tx;
        s_send_nack = nck;
        s_scl_level = scl_l;
        s_sda_level = sda_l;
        do @(posedge aclk); while (!s_ready);
        tick_res_q.push_back(predict_tick(req, tx, nck, scl_l, sda_l));
    endtask

    task automatic run_until_idle();
        int n;
        n = 0;
        while (seq_phase != PH_IDLE) begin
            if (n == IDLE_WAIT_MAX) begin
                fail_cnt++;
                $display("%0t: sequencer did not return to idle", $time);
                break;
            end
            send_tick(busy_req(), 8'($urandom), 1'($urandom));
            n++;
        end
    endtask

    task automatic do_cmd(input logic [2:0] req, input logic [7:0] tx, input logic nck);
        run_until_idle();
        send_tick(req, tx, nck);
        run_until_idle();
    endtask

    // registers change only with no tick word in flight
    task automatic write_reg(input logic idx, input logic [15:0] val);
        @(negedge aclk);
        s_valid = 1'b0;
        while (tick_res_q.size() != 0) @(negedge aclk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_wdata = val;
        @(negedge aclk);
        cfg_we = 1'b0;
        if (idx == CFG_LINE_DELAY) line_delay_cfg = val;
        else stretch_limit_cfg = val;
        burst_left = 0;
    endtask

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------
    task automatic test_defaults();
        ack_refuse = 1'b0;
        ack_late   = 0;
        do_cmd(REQ_START, 8'h00, 1'b0);
        do_cmd(REQ_STOP, 8'h00, 1'b0);
    endtask

    task automatic test_commands();
        write_reg(CFG_LINE_DELAY, 16'd0);
        write_reg(CFG_STRETCH_TIMEOUT, 16'd0);
        busy_cmd_pct = 0;
        send_tick(REQ_SPARE6, 8'hFF, 1'b1);
        send_tick(REQ_SPARE7, 8'h00, 1'b0);
        send_tick(REQ_NONE, 8'h55, 1'b1);
        do_cmd(REQ_START, 8'h00, 1'b0);
        do_cmd(REQ_WRITE, 8'h00, 1'b0);
        do_cmd(REQ_WRITE, 8'hFF, 1'b1);
        slave_byte = 8'hFF;
        do_cmd(REQ_READ, 8'h00, 1'b0);
        slave_byte = 8'h00;
        do_cmd(REQ_READ, 8'hFF, 1'b1);
        do_cmd(REQ_RESTART, 8'h00, 1'b0);
        // slave leaves sda high: no acknowledge
        ack_refuse = 1'b1;
        do_cmd(REQ_WRITE, 8'h5A, 1'b0);
        ack_refuse = 1'b0;
        // a stop is started; the commands offered while it is busy are dropped
        send_tick(REQ_STOP, 8'h00, 1'b0);
        send_tick(REQ_WRITE, 8'hC3, 1'b0);
        send_tick(REQ_READ, 8'h3C, 1'b1);
        run_until_idle();
        busy_cmd_pct = 5;
    endtask

    task automatic test_start_failure();
        // sda already low before the start edge
        force_sda_low = 1;
        do_cmd(REQ_START, 8'h00, 1'b0);
        force_sda_low = 0;
        // sda does not follow the master low
        force_sda_high = 1;
        do_cmd(REQ_RESTART, 8'h00, 1'b0);
        force_sda_high = 0;
        do_cmd(REQ_STOP, 8'h00, 1'b0);
    endtask

    task automatic test_stretching();
        write_reg(CFG_STRETCH_TIMEOUT, 16'hFFFF);
        stretch_pct = 30;
        stretch_max = 12;
        slave_byte  = 8'($urandom);
        do_cmd(REQ_START, 8'h00, 1'b0);
        do_cmd(REQ_WRITE, 8'($urandom), 1'b0);
        do_cmd(REQ_READ, 8'h00, 1'b0);
        do_cmd(REQ_STOP, 8'h00, 1'b0);
        // tight budget: stretches outlast it and the sequence moves on
        write_reg(CFG_STRETCH_TIMEOUT, 16'd2);
        stretch_max = 20;
        do_cmd(REQ_START, 8'h00, 1'b0);
        ack_late = 2;
        do_cmd(REQ_WRITE, 8'h96, 1'b0);
        ack_late = 12;
        do_cmd(REQ_WRITE, 8'h69, 1'b0);
        slave_byte = 8'hA7;
        do_cmd(REQ_READ, 8'h00, 1'b1);
        do_cmd(REQ_STOP, 8'h00, 1'b0);
        stretch_pct = 0;
        ack_late    = 0;
    endtask

    task automatic test_long_delay();
        gaps_on     = 0;
        rx_stall_on = 0;
        write_reg(CFG_LINE_DELAY, 16'd60);
        send_tick(REQ_START, 8'h00, 1'b0);
        // the first hold keeps the full count; later holds use the new value
        write_reg(CFG_LINE_DELAY, 16'd1);
        run_until_idle();
        do_cmd(REQ_STOP, 8'h00, 1'b0);
        gaps_on     = 1;
        rx_stall_on = 1;
    endtask

    task automatic test_backpressure();
        write_reg(CFG_LINE_DELAY, 16'd0);
        write_reg(CFG_STRETCH_TIMEOUT, 16'd4);
        gaps_on     = 0;
        rx_stall_on = 0;
        @(posedge aclk);
        hold_left = 300;
        do_cmd(REQ_START, 8'h00, 1'b0);
        do_cmd(REQ_WRITE, 8'hE1, 1'b0);
        do_cmd(REQ_STOP, 8'h00, 1'b0);
        gaps_on     = 1;
        rx_stall_on = 1;
    endtask

    task automatic random_traffic(input int n_ticks);
        int         r;
        logic [2:0] req;
        bit         in_txn;
        in_txn = 0;
        for (int i = 0; i < n_ticks; i++) begin
            if (seq_phase != PH_IDLE) begin
                req = busy_req();
            end else begin
                r = $urandom_range(0, 99);
                if (r < 8) req = REQ_NONE;
                else if (r < 12) req = 3'($urandom_range(REQ_SPARE6, REQ_SPARE7));
                else if (!in_txn) req = (r < 92) ? REQ_START
                                                 : 3'($urandom_range(REQ_WRITE, REQ_STOP));
                else if (r < 50) req = REQ_WRITE;
                else if (r < 75) req = REQ_READ;
                else if (r < 85) req = REQ_RESTART;
                else req = REQ_STOP;
                if (req == REQ_START || req == REQ_RESTART) in_txn = 1;
                if (req == REQ_STOP) in_txn = 0;
                ack_refuse = ($urandom_range(0, 9) == 0);
                ack_late   = $urandom_range(0, 4);
                slave_byte = 8'($urandom);
            end
            send_tick(req, 8'($urandom), 1'($urandom));
        end
    endtask

    task automatic test_random();
        logic [15:0] ld;
        logic [15:0] st;
        for (int k = 0; k < 6; k++) begin
            case (k)
                0: begin ld = 16'd0; st = 16'd0; end
                1: begin ld = 16'd1; st = 16'd1; end
                2: begin ld = 16'd2; st = 16'd4; end
                3: begin ld = 16'd3; st = 16'd20; end
                4: begin
                    ld = 16'($urandom_range(0, 4));
                    st = 16'($urandom_range(0, 8));
                end
                default: begin ld = 16'd0; st = 16'd60; end
            endcase
            write_reg(CFG_LINE_DELAY, ld);
            write_reg(CFG_STRETCH_TIMEOUT, st);
            noise_permil = $urandom_range(0, 15);
            stretch_pct  = $urandom_range(0, 20);
            stretch_max  = $urandom_range(1, 12);
            stuck_permil = $urandom_range(0, 20);
            gaps_on      = (k != 2);
            rx_stall_on  = (k != 3);
            random_traffic(25);
            run_until_idle();
        end
        noise_permil = 0;
        stretch_pct  = 0;
        stuck_permil = 0;
    endtask

    // ------------------------------------------------------------------------
    // result side
    // ------------------------------------------------------------------------
    always @(negedge aclk) begin
        rx_tick <= rx_tick + 1;
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else if (rx_stall_on) begin
            m_ready <= (rx_tick % 5 != 2) && ($urandom_range(0, 5) != 0);
        end else begin
            m_ready <= 1'b1;
        end
    end

    function automatic void check_field(input string what, input logic [7:0] want_v,
                                        input logic [7:0] got_v);
        if (got_v !== want_v) begin
            fail_cnt++;
            if (fail_cnt <= MAX_REPORTS)
                $display("%0t: %s mismatch, expected %0h, actual %0h",
                         $time, what, want_v, got_v);
        end
    endfunction

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (tick_res_q.size() == 0) begin
                fail_cnt++;
                if (fail_cnt <= MAX_REPORTS)
                    $display("%0t: result word with nothing expected", $time);
            end else begin
                want = tick_res_q.pop_front();
                check_field("scl_release", 8'(want.scl), 8'(m_scl_release));
                check_field("sda_release", 8'(want.sda), 8'(m_sda_release));
                check_field("busy", 8'(want.busy), 8'(m_busy_res));
                check_field("done", 8'(want.done), 8'(m_done_res));
                check_field("rx_byte", want.rx, m_rx_byte);
                check_field("error_code", 8'(want.err), 8'(m_error_code));
            end
        end
    end

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial begin
        int drain_n;
        aclk        = 1'b0;
        aresetn     = 1'b0;
        cfg_we      = 1'b0;
        cfg_index   = CFG_LINE_DELAY;
        cfg_wdata   = '0;
        s_valid     = 1'b0;
        s_req_type  = REQ_NONE;
        s_tx_byte   = '0;
        s_send_nack = 1'b0;
        s_scl_level = 1'b1;
        s_sda_level = 1'b1;
        m_ready     = 1'b0;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_defaults();
        test_commands();
        test_start_failure();
        test_stretching();
        test_long_delay();
        test_backpressure();
        test_random();

        @(negedge aclk);
        s_valid = 1'b0;
        drain_n = 0;
        while (tick_res_q.size() != 0 && drain_n < 2000) begin
            @(posedge aclk);
            drain_n++;
        end
        if (tick_res_q.size() != 0) begin
            fail_cnt++;
            $display("%0t: %0d result words never arrived", $time, tick_res_q.size());
        end
        repeat (4) @(posedge aclk);
        if (fail_cnt == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    initial begin
        #40_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule
